### rtl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants for the prefix code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int SYM_W   = 8;
    localparam int OP_W    = 2;
    localparam int BITS_W  = 4;
    // accumulator: up to 7 pending bits plus a full codeword, left-aligned
    localparam int ACC_W   = CODE_W + BYTE_W;
    localparam int CNT_W   = 6;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_MERGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic wr_valid;
        logic [CODE_W-1:0] wr_cw;
        logic [LEN_W-1:0]  wr_len;
        logic rd_en;
    } t_tbl_req;

    typedef struct packed {
        logic align;
        logic merge;
        logic emit;
        logic flush;
    } t_acc_cmd;

    typedef struct packed {
        logic has_byte;
        logic final_byte;
        logic has_pending;
    } t_acc_stat;

endpackage

### rtl/pcbp_code_table.sv
// ----------------------------------------------------------------------------
// pcbp_code_table
// Per-symbol codeword and length memory with a valid map cleared by reset.
// ----------------------------------------------------------------------------
module pcbp_code_table #(
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int CW_W         = pcbp_pkg::CODE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcbp_pkg::t_tbl_req            i_req,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] i_addr,
    output logic                          o_rd_valid,
    output logic [pcbp_pkg::CODE_W-1:0]   o_rd_cw,
    output logic [pcbp_pkg::LEN_W-1:0]    o_rd_len
);

    logic [SYMBOL_COUNT-1:0]         r_valid;
    logic [CW_W-1:0]                 r_mem_cw  [SYMBOL_COUNT];
    logic [pcbp_pkg::LEN_W-1:0]      r_mem_len [SYMBOL_COUNT];
    logic                            r_rd_valid;
    logic [CW_W-1:0]                 r_rd_cw;
    logic [pcbp_pkg::LEN_W-1:0]      r_rd_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_addr] <= i_req.wr_valid;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && i_req.wr_valid) begin
            r_mem_cw[i_addr]  <= i_req.wr_cw[CW_W-1:0];
            r_mem_len[i_addr] <= i_req.wr_len;
        end
        if (i_req.rd_en) begin
            r_rd_cw  <= r_mem_cw[i_addr];
            r_rd_len <= r_mem_len[i_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_cw    = pcbp_pkg::CODE_W'(r_rd_cw);
    assign o_rd_len   = r_rd_len;

endmodule

### rtl/pcbp_bit_acc.sv
// ----------------------------------------------------------------------------
// pcbp_bit_acc
// Left-aligned bit accumulator: aligns a codeword, merges it behind the
// pending bits, peels off bytes and right-aligns the partial byte to flush.
// ----------------------------------------------------------------------------
module pcbp_bit_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcbp_pkg::t_acc_cmd            i_cmd,
    input  logic [pcbp_pkg::CODE_W-1:0]   i_cw,
    input  logic [pcbp_pkg::LEN_W-1:0]    i_len,
    output pcbp_pkg::t_acc_stat           o_stat,
    output logic [pcbp_pkg::BYTE_W-1:0]   o_byte,
    output logic [pcbp_pkg::BYTE_W-1:0]   o_flush_byte,
    output logic [pcbp_pkg::BITS_W-1:0]   o_flush_bits
);

    logic [pcbp_pkg::CODE_W-1:0] r_cw_al;
    logic [pcbp_pkg::LEN_W-1:0]  r_len;
    logic [pcbp_pkg::ACC_W-1:0]  r_acc;
    logic [pcbp_pkg::CNT_W-1:0]  r_cnt;
    logic [pcbp_pkg::LEN_W-1:0]  align_sh;
    logic [pcbp_pkg::BITS_W-1:0] flush_sh;

    // bits above the length fall off the top here
    assign align_sh = pcbp_pkg::LEN_W'(pcbp_pkg::CODE_W) - i_len;

    always_ff @(posedge i_clk) begin
        if (i_cmd.align) begin
            r_cw_al <= i_cw << align_sh;
            r_len   <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.flush) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.merge) begin
            r_acc <= r_acc | ({r_cw_al, {pcbp_pkg::BYTE_W{1'b0}}} >> r_cnt);
            r_cnt <= r_cnt + pcbp_pkg::CNT_W'(r_len);
        end else if (i_cmd.emit) begin
            r_acc <= r_acc << pcbp_pkg::BYTE_W;
            r_cnt <= r_cnt - pcbp_pkg::CNT_W'(pcbp_pkg::BYTE_W);
        end
    end

    assign o_stat.has_byte    = r_cnt >= pcbp_pkg::CNT_W'(pcbp_pkg::BYTE_W);
    assign o_stat.final_byte  = r_cnt < pcbp_pkg::CNT_W'(2 * pcbp_pkg::BYTE_W);
    assign o_stat.has_pending = r_cnt != '0;

    assign o_byte = r_acc[pcbp_pkg::ACC_W-1 -: pcbp_pkg::BYTE_W];

    // right-align the partial byte
    assign flush_sh     = pcbp_pkg::BITS_W'(pcbp_pkg::BYTE_W)
                        - pcbp_pkg::BITS_W'(r_cnt[2:0]);
    assign o_flush_byte = o_byte >> flush_sh;
    assign o_flush_bits = pcbp_pkg::BITS_W'(r_cnt[2:0]);

endmodule

### rtl/prefix_code_bit_packer.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Loads a per-symbol prefix code table, appends codewords MSB first to a
// bit accumulator and streams out each completed byte; flush emits the
// pending partial byte right-aligned with its bit count.
//
//  channel  dir  tdata                                   tuser      tlast
//  s        in   symbol, code_bits, code_length          operation  -
//  m        out  out_byte, out_bits                      -          last
//
// Load and flush act on acceptance. Encode steps through table read, codeword
// align, merge and end check, then emits each completed byte as the output is
// free; an encode of a symbol with no valid entry ends after the table read.
// The input is not ready while an encode is in progress, or while the
// output word is held and the downstream side is not ready.
// Reset clears the valid map and the accumulator at once; no clearing pass.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // out_byte[7:0], out_bits[11:8]
    output logic        o_m_tlast    // last
);

    localparam int LEN_LIM = (MAX_CODE_LEN < pcbp_pkg::CODE_W) ?
                             MAX_CODE_LEN : pcbp_pkg::CODE_W;
    localparam int IDX_W   = $clog2(SYMBOL_COUNT);

    logic [pcbp_pkg::OP_W-1:0]   in_op;
    logic [pcbp_pkg::SYM_W-1:0]  in_sym;
    logic [pcbp_pkg::CODE_W-1:0] in_cw;
    logic [pcbp_pkg::LEN_W-1:0]  in_len;
    logic [pcbp_pkg::LEN_W-1:0]  len_clamp;
    logic                        sym_ok;
    logic                        in_acc;
    logic                        out_free;

    pcbp_pkg::t_state    r_state, n_state;
    pcbp_pkg::t_tbl_req  tbl_req;
    pcbp_pkg::t_acc_cmd  acc_cmd;
    pcbp_pkg::t_acc_stat acc_stat;

    logic                          rd_valid;
    logic [pcbp_pkg::CODE_W-1:0]   rd_cw;
    logic [pcbp_pkg::LEN_W-1:0]    rd_len;
    logic [pcbp_pkg::BYTE_W-1:0]   acc_byte;
    logic [pcbp_pkg::BYTE_W-1:0]   flush_byte;
    logic [pcbp_pkg::BITS_W-1:0]   flush_bits;

    logic                          r_out_valid;
    logic [pcbp_pkg::BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic [pcbp_pkg::BITS_W-1:0]   r_out_bits, n_out_bits;
    logic                          r_out_last, n_out_last;
    logic                          out_load;

    assign in_sym = i_s_tdata[7:0];
    assign in_cw  = i_s_tdata[39:8];
    assign in_len = i_s_tdata[45:40];
    assign in_op  = i_s_tuser;

    assign sym_ok    = {1'b0, in_sym} < 9'(SYMBOL_COUNT);
    assign len_clamp = (in_len > pcbp_pkg::LEN_W'(LEN_LIM)) ?
                       pcbp_pkg::LEN_W'(LEN_LIM) : in_len;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == pcbp_pkg::ST_IDLE) && out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;

    pcbp_code_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CW_W         (LEN_LIM)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .i_addr     (in_sym[IDX_W-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_cw    (rd_cw),
        .o_rd_len   (rd_len)
    );

    pcbp_bit_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (acc_cmd),
        .i_cw         (rd_cw),
        .i_len        (rd_len),
        .o_stat       (acc_stat),
        .o_byte       (acc_byte),
        .o_flush_byte (flush_byte),
        .o_flush_bits (flush_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        tbl_req.wr_en   = 1'b0;
        tbl_req.wr_valid = len_clamp != '0;
        tbl_req.wr_cw   = in_cw;
        tbl_req.wr_len  = len_clamp;
        tbl_req.rd_en   = 1'b0;
        acc_cmd         = '0;
        out_load        = 1'b0;
        n_out_byte      = acc_byte;
        n_out_bits      = pcbp_pkg::BITS_W'(pcbp_pkg::BYTE_W);
        n_out_last      = acc_stat.final_byte;
        case (r_state)
            pcbp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        pcbp_pkg::OP_LOAD: begin
                            tbl_req.wr_en = sym_ok;
                        end
                        pcbp_pkg::OP_ENCODE: begin
                            if (sym_ok) begin
                                tbl_req.rd_en = 1'b1;
                                n_state       = pcbp_pkg::ST_LOOK;
                            end
                        end
                        pcbp_pkg::OP_FLUSH: begin
                            if (acc_stat.has_pending) begin
                                out_load      = 1'b1;
                                n_out_byte    = flush_byte;
                                n_out_bits    = flush_bits;
                                n_out_last    = 1'b1;
                                acc_cmd.flush = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pcbp_pkg::ST_LOOK: begin
                // drop symbols with no valid entry
                if (rd_valid) begin
                    acc_cmd.align = 1'b1;
                    n_state       = pcbp_pkg::ST_MERGE;
                end else begin
                    n_state = pcbp_pkg::ST_IDLE;
                end
            end
            pcbp_pkg::ST_MERGE: begin
                acc_cmd.merge = 1'b1;
                n_state       = pcbp_pkg::ST_EMIT;
            end
            pcbp_pkg::ST_EMIT: begin
                if (!acc_stat.has_byte) begin
                    n_state = pcbp_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    acc_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = pcbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_bits <= n_out_bits;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_bits, r_out_byte};
    assign o_m_tlast  = r_out_last;

endmodule
